// ===== src/gtm_pkg.sv =====
// Shared types and constants for the tiled median block.
package gtm_pkg;

    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLUMNS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS    = 3'd4;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_begin;
    } pix_req_t;

    typedef struct packed {
        logic [7:0] tile_median;
        logic [4:0] tile_col;
        logic [4:0] tile_row;
        logic       frame_done;
    } med_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_WRITE,
        ST_SUM,
        ST_SCAN,
        ST_HOLD,
        ST_ADV
    } gtm_state_t;

endpackage

// ===== src/grid_tile_median.sv =====
// Top level of the tiled median block: position tracking, histogram sequencer, output register.
//
// Pixels enter in raster order on the pix channel (valid/ready), one request per pixel.
// A request with frame_begin set restarts the position at the top-left corner and
// clears every histogram before its pixel is counted. Each tile column owns a
// 256-bin histogram in one memory; a pixel costs one read and one write of its bin.
// A pixel inside the grid passes through READ, WRITE and ADV before the next can be taken,
// and a pixel outside the grid through ADV alone.
// The bottom-right pixel of a tile starts two sweeps over that column's 256 bins
// (count, then rank search with clearing), after which the
// tile's median is placed in the med output register.
// A frame_begin request adds a clearing pass over 256 * 2**ceil(log2(MAX_TILE_COLUMNS))
// bins (8192 by default); the same pass runs after reset before any pixel is taken.
// A write of tile_width makes the block recompute the column position.
// A waiting median does not block further pixels; the next finished tile holds, with
// pix_ready low, until the med receiver takes the previous one.
// Configuration writes are registered and must be made while the block is idle.
module grid_tile_median
    import gtm_pkg::*;
#(
    parameter int MAX_TILE_COLUMNS = 32,
    parameter int COUNT_BITS       = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  pix_req_t              pix_data,
    output logic                  med_valid,
    input  logic                  med_ready,
    output med_req_t              med_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CB     = (MAX_TILE_COLUMNS > 1) ? $clog2(MAX_TILE_COLUMNS) : 1;
    localparam int AW     = CB + 8;
    localparam int NW     = COUNT_BITS + 8;
    localparam int TC_CAP = (MAX_TILE_COLUMNS < 32) ? MAX_TILE_COLUMNS : 32;

    gtm_state_t state_reg, state_next;

    logic [12:0] line_width_reg;
    logic [7:0]  tile_width_reg;
    logic [7:0]  tile_height_reg;
    logic [5:0]  tile_columns_reg;
    logic [5:0]  tile_rows_reg;
    logic        dirty_reg;

    logic [11:0] x_reg;
    logic [7:0]  xt_reg;
    logic [11:0] col_reg;
    logic [7:0]  y_reg;
    logic [5:0]  row_reg;

    logic [7:0]  pix_reg;
    logic [AW:0] clr_reg;
    logic [8:0]  idx_reg;
    logic [3:0]  div_cnt_reg;
    logic [11:0] div_x_reg;
    logic [8:0]  div_rem_reg;
    logic [11:0] div_q_reg;

    logic [NW-1:0] n_reg;
    logic [NW-1:0] cum_reg;
    logic [7:0]    v1_reg, v2_reg;
    logic          f1_reg, f2_reg;

    logic     out_valid_reg;
    med_req_t out_reg;

    logic [12:0] lw_eff;
    logic [7:0]  tw_eff, th_eff;
    logic [6:0]  tc_eff;
    logic [5:0]  tr_eff;
    logic [5:0]  tc_raw;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;

    logic in_grid, tile_last, slot_free, out_load;
    logic [NW-1:0] r1, r2, cum_sum;
    logic [7:0]    bin_idx;
    logic [8:0]    med_sum;
    logic [9:0]    div_trial;

    assign lw_eff = (line_width_reg == 13'd0) ? 13'd1 :
                    (line_width_reg > 13'd4096) ? 13'd4096 : line_width_reg;
    assign tw_eff = (tile_width_reg == 8'd0) ? 8'd1 : tile_width_reg;
    assign th_eff = (tile_height_reg == 8'd0) ? 8'd1 : tile_height_reg;
    assign tc_raw = (tile_columns_reg == 6'd0) ? 6'd1 : tile_columns_reg;
    assign tc_eff = ({1'b0, tc_raw} > 7'(TC_CAP)) ? 7'(TC_CAP) : {1'b0, tc_raw};
    assign tr_eff = (tile_rows_reg == 6'd0) ? 6'd1 :
                    (tile_rows_reg > 6'd32) ? 6'd32 : tile_rows_reg;

    assign in_grid   = (row_reg < tr_eff) && (y_reg < th_eff) && (col_reg < {5'd0, tc_eff});
    assign tile_last = (y_reg == th_eff - 8'd1) && (xt_reg == tw_eff - 8'd1);
    assign slot_free = !out_valid_reg || med_ready;
    assign out_load  = ((state_reg == ST_SCAN && idx_reg == 9'd256) || state_reg == ST_HOLD)
                       && slot_free;

    assign r2      = n_reg >> 1;
    assign r1      = n_reg[0] ? r2 : r2 - NW'(1);
    assign bin_idx = 8'(idx_reg - 9'd1);
    assign cum_sum = cum_reg + NW'(mem_rdata);
    assign med_sum = {1'b0, v1_reg} + {1'b0, v2_reg};
    assign div_trial = {div_rem_reg, div_x_reg[11]};

    gtm_hist_ram #(
        .ADDR_W (AW),
        .DATA_W (COUNT_BITS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg[AW])
                begin
                    state_next = (idx_reg[0]) ? ST_READ : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (dirty_reg)
                begin
                    state_next = ST_DIV;
                end
                else if (pix_valid)
                begin
                    if (pix_data.frame_begin)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (in_grid)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_ADV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == 4'd11)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:  state_next = ST_WRITE;
            ST_WRITE: state_next = tile_last ? ST_SUM : ST_ADV;
            ST_SUM:
            begin
                if (idx_reg == 9'd256)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == 9'd256)
                begin
                    state_next = slot_free ? ST_ADV : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pix_ready = (state_reg == ST_IDLE) && !dirty_reg;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = {col_reg[CB-1:0], pix_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = !clr_reg[AW];
                mem_waddr = clr_reg[AW-1:0];
            end
            ST_WRITE:
            begin
                mem_we    = 1'b1;
                mem_waddr = {col_reg[CB-1:0], pix_reg};
                mem_wdata = (&mem_rdata) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
            end
            ST_SUM:
            begin
                mem_raddr = {col_reg[CB-1:0], idx_reg[7:0]};
            end
            ST_SCAN:
            begin
                mem_raddr = {col_reg[CB-1:0], idx_reg[7:0]};
                mem_we    = (idx_reg != 9'd0);
                mem_waddr = {col_reg[CB-1:0], bin_idx};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            line_width_reg   <= 13'd1920;
            tile_width_reg   <= 8'd60;
            tile_height_reg  <= 8'd33;
            tile_columns_reg <= 6'd32;
            tile_rows_reg    <= 6'd32;
            dirty_reg        <= 1'b0;
            x_reg            <= '0;
            xt_reg           <= '0;
            col_reg          <= '0;
            y_reg            <= '0;
            row_reg          <= '0;
            clr_reg          <= '0;
            idx_reg          <= '0;
            div_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_LINE_WIDTH:   line_width_reg   <= cfg_data;
                    CFG_TILE_WIDTH:
                    begin
                        tile_width_reg <= cfg_data[7:0];
                        dirty_reg      <= 1'b1;
                    end
                    CFG_TILE_HEIGHT:  tile_height_reg  <= cfg_data[7:0];
                    CFG_TILE_COLUMNS: tile_columns_reg <= cfg_data[5:0];
                    CFG_TILE_ROWS:    tile_rows_reg    <= cfg_data[5:0];
                    default:          ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (med_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (!clr_reg[AW])
                    begin
                        clr_reg <= clr_reg + (AW+1)'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (dirty_reg)
                    begin
                        div_cnt_reg <= '0;
                    end
                    else if (pix_valid && pix_data.frame_begin)
                    begin
                        clr_reg <= '0;
                        idx_reg <= 9'd1;
                        x_reg   <= '0;
                        xt_reg  <= '0;
                        col_reg <= '0;
                        y_reg   <= '0;
                        row_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg + 4'd1;
                    if (div_cnt_reg == 4'd11)
                    begin
                        dirty_reg <= 1'b0;
                        if (div_trial >= {2'b00, tw_eff})
                        begin
                            xt_reg  <= 8'(div_trial - {2'b00, tw_eff});
                            col_reg <= {div_q_reg[10:0], 1'b1};
                        end
                        else
                        begin
                            xt_reg  <= div_trial[7:0];
                            col_reg <= {div_q_reg[10:0], 1'b0};
                        end
                    end
                end
                ST_WRITE:
                begin
                    idx_reg <= '0;
                end
                ST_SUM:
                begin
                    idx_reg <= (idx_reg == 9'd256) ? 9'd0 : idx_reg + 9'd1;
                end
                ST_SCAN:
                begin
                    if (idx_reg != 9'd256)
                    begin
                        idx_reg <= idx_reg + 9'd1;
                    end
                end
                ST_ADV:
                begin
                    if ({1'b0, x_reg} + 13'd1 >= lw_eff)
                    begin
                        x_reg   <= '0;
                        xt_reg  <= '0;
                        col_reg <= '0;
                        if ({1'b0, y_reg} + 9'd1 >= {1'b0, th_eff})
                        begin
                            y_reg <= '0;
                            if (row_reg != 6'd63)
                            begin
                                row_reg <= row_reg + 6'd1;
                            end
                        end
                        else
                        begin
                            y_reg <= y_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        x_reg <= x_reg + 12'd1;
                        if ({1'b0, xt_reg} + 9'd1 >= {1'b0, tw_eff})
                        begin
                            xt_reg  <= '0;
                            col_reg <= col_reg + 12'd1;
                        end
                        else
                        begin
                            xt_reg <= xt_reg + 8'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && pix_ready && pix_valid)
        begin
            pix_reg <= pix_data.pixel;
        end

        if (state_reg == ST_IDLE)
        begin
            div_x_reg   <= x_reg;
            div_rem_reg <= '0;
            div_q_reg   <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            div_x_reg <= {div_x_reg[10:0], 1'b0};
            if (div_trial >= {2'b00, tw_eff})
            begin
                div_rem_reg <= 9'(div_trial - {2'b00, tw_eff});
                div_q_reg   <= {div_q_reg[10:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_trial[8:0];
                div_q_reg   <= {div_q_reg[10:0], 1'b0};
            end
        end

        if (state_reg == ST_WRITE)
        begin
            n_reg <= '0;
        end
        else if (state_reg == ST_SUM && idx_reg != 9'd0)
        begin
            n_reg <= n_reg + NW'(mem_rdata);
        end

        if (state_reg == ST_SUM)
        begin
            cum_reg <= '0;
            v1_reg  <= 8'd255;
            v2_reg  <= 8'd255;
            f1_reg  <= 1'b0;
            f2_reg  <= 1'b0;
        end
        else if (state_reg == ST_SCAN && idx_reg != 9'd0)
        begin
            cum_reg <= cum_sum;
            if (!f1_reg && cum_sum > r1)
            begin
                v1_reg <= bin_idx;
                f1_reg <= 1'b1;
            end
            if (!f2_reg && cum_sum > r2)
            begin
                v2_reg <= bin_idx;
                f2_reg <= 1'b1;
            end
        end

        if (out_load)
        begin
            out_reg.tile_median <= (n_reg == '0) ? 8'd0 : med_sum[8:1];
            out_reg.tile_col    <= col_reg[4:0];
            out_reg.tile_row    <= row_reg[4:0];
            out_reg.frame_done  <= (col_reg == {5'd0, tc_eff - 7'd1})
                                   && (row_reg == tr_eff - 6'd1);
        end
    end

    assign med_valid = out_valid_reg;
    assign med_data  = out_reg;

`ifndef ASSERT_OFF
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !mem_we)
        else $error("histogram written while idle");

    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM || state_reg == ST_SCAN) |-> idx_reg <= 9'd256)
        else $error("bin sweep index out of range");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> med_valid)
        else $error("finished median not presented");
`endif

endmodule

// ===== src/gtm_hist_ram.sv =====
// Histogram memory with one write port and one registered read port.
module gtm_hist_ram #(
    parameter int ADDR_W = 13,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
